>>> src/qspd_pkg.sv
// shared types, character codes and hex digit decode for the query string pair decoder
package qspd_pkg;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam int unsigned NIBBLE_W = 4;

    localparam logic REG_PLUS_AS_SPACE = 1'b0;
    localparam logic REG_SPLIT_PAIRS   = 1'b1;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } escape_phase_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] val;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t d;
        logic [7:0] diff;
        d    = '0;
        diff = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            diff  = c - 8'h30;
            d.ok  = 1'b1;
            d.val = diff[NIBBLE_W-1:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            diff  = c - 8'h37;
            d.ok  = 1'b1;
            d.val = diff[NIBBLE_W-1:0];
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            diff  = c - 8'h57;
            d.ok  = 1'b1;
            d.val = diff[NIBBLE_W-1:0];
        end
        return d;
    endfunction

endpackage

>>> src/query_string_pair_decoder.sv
// query string pair decoder: streaming percent decoder with name/value pair splitting
//
// Takes one raw character per item and gives at most one result item for it. A new
// item can be accepted in every cycle while the output is not stalled; a result follows its
// item through an input register and then a result register, and the result register
// lets the next item be taken while a finished result waits. Characters that give no
// result (a '%', the first hex digit of an escape, the first '=' of a pair, anything
// after a bad escape) still pass through the input register. The item with in_last set
// always gives a result with string_end high and leaves the block ready for the next
// string. Register 0 (address 0) is plus_as_space, register 1 (address 4) is
// split_pairs; both reset to 1 and are to be written only while the block is idle.
module query_string_pair_decoder
    import qspd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        is_value,
    output logic        pair_end,
    output logic        string_end,
    output logic        bad_escape
);

    // configuration
    logic plus_as_space_reg;
    logic split_pairs_reg;
    logic cfg_write;
    logic cfg_index;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // string state
    escape_phase_t        phase_reg;
    escape_phase_t        phase_next;
    logic [NIBBLE_W-1:0]  nibble_reg;
    logic [NIBBLE_W-1:0]  nibble_next;
    logic                 value_part_reg;
    logic                 value_part_next;
    logic                 value_part_upd;
    logic                 error_reg;
    logic                 error_next;
    logic                 error_upd;
    logic                 err;

    // result register
    logic       out_valid_reg;
    logic       byte_valid_reg;
    logic [7:0] out_byte_reg;
    logic       is_value_reg;
    logic       pair_end_reg;
    logic       string_end_reg;
    logic       bad_escape_reg;

    // result of the current item
    logic       emit;
    logic       res_bv;
    logic [7:0] res_byte;
    logic       res_isv;
    logic       res_pe;
    logic       res_se;
    logic       res_be;
    logic       isv_fixed;

    logic       advance;
    logic       fire;
    logic [7:0] chr;
    logic       is_pct;
    logic       is_amp;
    logic       is_eq;
    hex_digit_t hex;

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];
    assign pready    = 1'b1;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_PLUS_AS_SPACE: prdata[0] = plus_as_space_reg;
            REG_SPLIT_PAIRS:   prdata[0] = split_pairs_reg;
            default:           prdata    = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_as_space_reg <= 1'b1;
            split_pairs_reg   <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_PLUS_AS_SPACE)
                plus_as_space_reg <= pwdata[0];
            if (cfg_index == REG_SPLIT_PAIRS)
                split_pairs_reg <= pwdata[0];
        end
    end

    // handshake
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= in_byte;
            s1_last_reg <= in_last;
        end
    end

    // character classification
    assign chr    = (plus_as_space_reg && s1_byte_reg == CHAR_PLUS) ? CHAR_SPACE : s1_byte_reg;
    assign hex    = hex_decode(s1_byte_reg);
    assign is_pct = (chr == CHAR_PERCENT);
    assign is_amp = split_pairs_reg && (chr == CHAR_AMP);
    assign is_eq  = split_pairs_reg && (chr == CHAR_EQUALS) && !value_part_reg;

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        nibble_next    = nibble_reg;
        value_part_upd = value_part_reg;
        error_upd      = error_reg;
        err            = 1'b0;
        if (!error_reg)
        begin
            unique case (phase_reg)
                PH_HIGH:
                begin
                    if (hex.ok)
                    begin
                        nibble_next = hex.val;
                        phase_next  = PH_LOW;
                    end
                    else
                        err = 1'b1;
                end
                PH_LOW:
                begin
                    if (hex.ok)
                        phase_next = PH_PLAIN;
                    else
                        err = 1'b1;
                end
                PH_PLAIN:
                begin
                    if (is_pct)
                        phase_next = PH_HIGH;
                    else if (is_amp)
                        value_part_upd = 1'b0;
                    else if (is_eq)
                        value_part_upd = 1'b1;
                end
                default: phase_next = PH_PLAIN;
            endcase
            if (s1_last_reg && phase_next != PH_PLAIN)
                err = 1'b1;
            if (err)
                error_upd = 1'b1;
        end
        value_part_next = value_part_upd;
        error_next      = error_upd;
        if (s1_last_reg)
        begin
            phase_next      = PH_PLAIN;
            nibble_next     = '0;
            value_part_next = 1'b0;
            error_next      = 1'b0;
        end
    end

    // result of the item
    always_comb
    begin
        emit      = 1'b0;
        res_bv    = 1'b0;
        res_byte  = '0;
        res_isv   = 1'b0;
        res_pe    = 1'b0;
        res_se    = 1'b0;
        res_be    = 1'b0;
        isv_fixed = 1'b0;
        if (!error_reg)
        begin
            unique case (phase_reg)
                PH_LOW:
                begin
                    if (hex.ok)
                    begin
                        res_bv   = 1'b1;
                        res_byte = {nibble_reg, hex.val};
                        emit     = 1'b1;
                    end
                end
                PH_PLAIN:
                begin
                    if (is_amp)
                    begin
                        res_pe    = 1'b1;
                        res_isv   = value_part_reg;
                        isv_fixed = 1'b1;
                        emit      = 1'b1;
                    end
                    else if (!is_pct && !is_eq)
                    begin
                        res_bv   = 1'b1;
                        res_byte = chr;
                        emit     = 1'b1;
                    end
                end
                default: emit = 1'b0;
            endcase
        end
        if (err)
        begin
            res_be   = 1'b1;
            res_bv   = 1'b0;
            res_byte = '0;
            emit     = 1'b1;
        end
        if (!isv_fixed)
            res_isv = value_part_upd;
        if (!split_pairs_reg)
            res_isv = 1'b0;
        if (s1_last_reg)
        begin
            res_se = 1'b1;
            res_be = error_upd;
            res_pe = split_pairs_reg;
            emit   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PLAIN;
            nibble_reg     <= '0;
            value_part_reg <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg      <= phase_next;
                nibble_reg     <= nibble_next;
                value_part_reg <= value_part_next;
                error_reg      <= error_next;
            end
            if (advance)
                out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            byte_valid_reg <= res_bv;
            out_byte_reg   <= res_byte;
            is_value_reg   <= res_isv;
            pair_end_reg   <= res_pe;
            string_end_reg <= res_se;
            bad_escape_reg <= res_be;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_valid = byte_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_value   = is_value_reg;
    assign pair_end   = pair_end_reg;
    assign string_end = string_end_reg;
    assign bad_escape = bad_escape_reg;

endmodule
